/* design/mrcm_pkg.sv */
// Package: shared constants, op codes and register indexes of the RMS current monitor.
`default_nettype none
package mrcm_pkg;
   localparam int CHANNELS_DEFAULT = 16;
   localparam int ADC_BITS_DEFAULT = 10;

   localparam logic [15:0] MASK_RESET     = 16'd30583;
   localparam logic [15:0] MINSAMP_RESET  = 16'd80;
   localparam logic [23:0] GAIN_RESET     = 24'd3203158;
   localparam logic [15:0] DEADBAND_RESET = 16'd500;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_REPORT = 2'd1;
   localparam logic [1:0] OP_OFFSET = 2'd2;

   localparam logic [1:0] REG_MASK     = 2'd0;
   localparam logic [1:0] REG_MINSAMP  = 2'd1;
   localparam logic [1:0] REG_GAIN     = 2'd2;
   localparam logic [1:0] REG_DEADBAND = 2'd3;
endpackage
`default_nettype wire

/* design/multichannel_rms_current_monitor.sv */
// Top level of the multichannel RMS current monitor.
`default_nettype none
// The monitor accepts items on the req_ stream and returns report results on
// the rsp_ stream. Each request item carries an op, an ADC value and a target
// channel. A sample item adds the squared, offset-corrected value to the
// accumulator of the next fitted channel in the scan; it looks up the scan
// target, reads the channel's memory entry and writes the updated entry
// back. An offset write likewise reads the entry and writes it back with
// the new offset. A report item walks all channels in order; each channel
// is read from the state memory and, where it has at least min_samples
// samples, goes through a bit-serial restoring divider and a square root
// that settles two bits a cycle, followed by one gain multiply. One item
// is in work at a time.
// Results leave through an output register: the block waits while the
// receiver stalls and holds the result steady. A synchronous reset
// empties all accumulators, counts, offsets and held currents by means of
// per-channel valid bits, and restores the register defaults at once, so
// the block accepts items in the cycle after reset is released.
// Configuration lies on the csr_ APB-style port at byte addresses 0, 4, 8, 12.
module multichannel_rms_current_monitor
   import mrcm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: op[1:0], adc_value[11:2], target_channel[15:12]
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: channel[3:0], irms_ma[19:4], zero fill above
   output logic [23:0]      rsp_tdata,
   // tuser: updated
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int CW  = $clog2(CHANNELS);
   localparam int CW1 = CW + 1;
   localparam int MW  = 32 + 16 + 10 + 16;   // sum, count, offset, held

   typedef enum logic [3:0] {
      S_IDLE, S_SREAD, S_SWRITE, S_RREAD, S_RCHECK, S_DIV, S_SQRT,
      S_MUL, S_FIN, S_OUT
   } state_type;

   // Configuration registers.
   logic [15:0] mask_ff, minsamp_ff, deadband_ff;
   logic [23:0] gain_ff;
   logic        wr_en;
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= MASK_RESET;
         minsamp_ff  <= MINSAMP_RESET;
         gain_ff     <= GAIN_RESET;
         deadband_ff <= DEADBAND_RESET;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_MASK:     mask_ff     <= csr_pwdata[15:0];
            REG_MINSAMP:  minsamp_ff  <= csr_pwdata[15:0];
            REG_GAIN:     gain_ff     <= csr_pwdata[23:0];
            REG_DEADBAND: deadband_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MASK:     csr_prdata = {16'd0, mask_ff};
         REG_MINSAMP:  csr_prdata = {16'd0, minsamp_ff};
         REG_GAIN:     csr_prdata = {8'd0, gain_ff};
         REG_DEADBAND: csr_prdata = {16'd0, deadband_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // State memory: one entry per channel holding its sum, count, offset and held current.
   logic [MW-1:0]       mem [CHANNELS];
   logic [MW-1:0]       rd_data_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic                valid_rd_ff;
   logic [CW-1:0]       addr_ff;
   logic                mem_we;
   logic [MW-1:0]       mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr_ff] <= mem_wd;
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_rd_ff <= 1'b0;
      else       valid_rd_ff <= valid_ff[addr_ff];
   end

   // Entry fields, with an unwritten entry reading as zero.
   logic [31:0]         e_sum;
   logic [15:0]         e_cnt, e_held;
   logic [9:0]          e_off;
   assign {e_sum, e_cnt, e_off, e_held} = valid_rd_ff ? rd_data_ff : '0;

   // Request fields.
   logic [1:0]          in_op;
   logic [ADC_BITS-1:0] in_adc;
   logic [3:0]          in_tgt;
   assign in_op  = req_tdata[1:0];
   assign in_adc = ADC_BITS'(req_tdata[11:2]);
   assign in_tgt = req_tdata[15:12];

   // Next fitted channel at or after the scan pointer.
   logic [CHANNELS-1:0] fitted;
   logic [CW-1:0]       scan_ff, hit_ch;
   logic                hit;
   always_comb begin
      logic [CW1-1:0] c;
      fitted = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i < 16) fitted[i] = mask_ff[i[3:0]];
      end
      hit    = 1'b0;
      hit_ch = '0;
      for (int k = CHANNELS - 1; k >= 0; k--) begin
         c = CW1'(scan_ff) + CW1'(k);
         if (c >= CW1'(CHANNELS)) c = c - CW1'(CHANNELS);
         if (fitted[c[CW-1:0]]) begin
            hit    = 1'b1;
            hit_ch = c[CW-1:0];
         end
      end
   end

   state_type           state_ff;
   logic [ADC_BITS-1:0] adc_ff;
   logic [1:0]          op_ff;
   logic [47:0]         rem_ff, quo_ff;
   logic [5:0]          step_ff;
   logic [31:0]         rad_ff, root_ff;
   logic [33:0]         rtrem_ff;
   logic [47:0]         prod_ff;
   logic [15:0]         out_ma_ff;
   logic                out_upd_ff;
   logic [15:0]         need;

   assign need = (minsamp_ff == 16'd0) ? 16'd1 : minsamp_ff;
   assign req_tready = (state_ff == S_IDLE) && !reset;

   // Sample arithmetic.
   logic signed [16:0]  diff;
   logic [32:0]         sq, new_sum;
   logic [31:0]         sat_sum;
   logic [15:0]         new_cnt;
   assign diff    = $signed({1'b0, 16'(adc_ff)}) - $signed({7'd0, e_off});
   assign sq      = 33'(32'(diff * diff));
   assign new_sum = {1'b0, e_sum} + sq;
   assign sat_sum = new_sum[32] ? 32'hFFFF_FFFF : new_sum[31:0];
   assign new_cnt = (e_cnt == 16'hFFFF) ? e_cnt : e_cnt + 16'd1;

   // Restoring divider step: dividend sum<<16 shifted in MSB first.
   logic [48:0] div_trial;
   logic [47:0] div_rem_sh;
   assign div_rem_sh = {rem_ff[46:0], quo_ff[47]};
   assign div_trial  = {1'b0, div_rem_sh} - {33'd0, e_cnt};

   // Square-root step over the 48-bit mean, two bits a cycle.
   logic [33:0] rt_sh, rt_trial;
   assign rt_sh    = {rtrem_ff[31:0], quo_ff[47:46]};
   assign rt_trial = rt_sh - {root_ff, 2'b01};

   // Scaled current, saturated to 16 bits, then the deadband.
   logic [15:0] ma_sat, ma_new;
   assign ma_sat = (|prod_ff[47:40]) ? 16'hFFFF : prod_ff[39:24];
   assign ma_new = (ma_sat < deadband_ff) ? 16'd0 : ma_sat;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = {e_sum, e_cnt, e_off, e_held};
      if (state_ff == S_SWRITE) begin
         mem_we = 1'b1;
         if (op_ff == OP_OFFSET) mem_wd = {e_sum, e_cnt, 10'(adc_ff), e_held};
         else                    mem_wd = {sat_sum, new_cnt, e_off, e_held};
      end else if (state_ff == S_FIN) begin
         mem_we = out_upd_ff;
         mem_wd = {32'd0, 16'd0, e_off, ma_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         scan_ff    <= '0;
         valid_ff   <= '0;
         rsp_tvalid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  adc_ff <= in_adc;
                  op_ff  <= in_op;
                  if (in_op == OP_SAMPLE && hit) begin
                     addr_ff  <= hit_ch;
                     scan_ff  <= (32'(hit_ch) == CHANNELS - 1) ? '0 : hit_ch + CW'(1);
                     state_ff <= S_SREAD;
                  end else if (in_op == OP_REPORT) begin
                     addr_ff  <= '0;
                     state_ff <= S_RREAD;
                  end else if (in_op == OP_OFFSET && 32'(in_tgt) < CHANNELS) begin
                     addr_ff  <= CW'(in_tgt);
                     state_ff <= S_SREAD;
                  end
               end
            end
            S_SREAD: state_ff <= S_SWRITE;
            S_SWRITE: begin
               valid_ff[addr_ff] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_RREAD: state_ff <= S_RCHECK;
            S_RCHECK: begin
               out_ma_ff  <= e_held;
               out_upd_ff <= (e_cnt >= need);
               rem_ff     <= '0;
               quo_ff     <= {e_sum, 16'd0};
               step_ff    <= '0;
               state_ff   <= (e_cnt >= need) ? S_DIV : S_FIN;
            end
            S_DIV: begin
               if (!div_trial[48]) begin
                  rem_ff <= div_trial[47:0];
                  quo_ff <= {quo_ff[46:0], 1'b1};
               end else begin
                  rem_ff <= div_rem_sh;
                  quo_ff <= {quo_ff[46:0], 1'b0};
               end
               if (step_ff == 6'd47) begin
                  step_ff  <= '0;
                  root_ff  <= '0;
                  rtrem_ff <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_SQRT: begin
               quo_ff <= {quo_ff[45:0], 2'b00};
               if (!rt_trial[33] || rt_sh >= {root_ff, 2'b01}) begin
                  rtrem_ff <= rt_trial;
                  root_ff  <= {root_ff[30:0], 1'b1};
               end else begin
                  rtrem_ff <= rt_sh;
                  root_ff  <= {root_ff[30:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd23) state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= 48'(root_ff[23:0]) * 48'(gain_ff);
               state_ff <= S_FIN;
               out_ma_ff <= 16'd0;
            end
            S_FIN: begin
               if (out_upd_ff) begin
                  out_ma_ff <= ma_new;
               end
               valid_ff[addr_ff] <= valid_ff[addr_ff];
               rsp_tvalid <= 1'b1;
               state_ff   <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  if (32'(addr_ff) == CHANNELS - 1) begin
                     state_ff <= S_IDLE;
                  end else begin
                     addr_ff  <= addr_ff + CW'(1);
                     state_ff <= S_RREAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {4'd0, out_ma_ff, 4'(addr_ff)};
   assign rsp_tuser = out_upd_ff;
   assign rsp_tlast = (32'(addr_ff) == CHANNELS - 1);
endmodule
`default_nettype wire

/* sim/mrcm_checker.sv */
// Checker for the RMS current monitor: predicts every report result and compares it.
`timescale 1ns / 100ps
module mrcm_checker
   import mrcm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               error_count,
   output int               pending
);

   typedef struct packed {
      logic [3:0]  channel;
      logic [15:0] irms_ma;
      logic        updated;
      logic        last;
   } channel_report_type;

   channel_report_type expected_reports[$];

   logic [15:0] present_mask;
   logic [15:0] min_count;
   logic [23:0] gain_q16;
   logic [15:0] deadband;
   logic [31:0] square_acc [16];
   logic [15:0] sample_cnt [16];
   logic [9:0]  offset_val [16];
   logic [15:0] held_ma    [16];
   logic [3:0]  scan_ptr;

   assign pending = expected_reports.size();

   // Integer square root of a Q16 mean square; the root fits in 24 bits.
   function automatic logic [23:0] root_of_mean(input logic [47:0] v);
      logic [23:0] r;
      r = '0;
      for (int b = 23; b >= 0; b--) begin
         r[b] = 1'b1;
         if ({24'd0, r} * {24'd0, r} > v) r[b] = 1'b0;
      end
      return r;
   endfunction

   task automatic accumulate_sample(input logic [9:0] adc);
      logic [3:0]  ch;
      int          d;
      logic [32:0] total;
      for (int k = 0; k < 16; k++) begin
         ch = scan_ptr + 4'(k);
         if (present_mask[ch]) begin
            d = int'(adc) - int'(offset_val[ch]);
            total = {1'b0, square_acc[ch]} + 33'(d * d);
            square_acc[ch] = total[32] ? 32'hFFFF_FFFF : total[31:0];
            if (sample_cnt[ch] != 16'hFFFF) sample_cnt[ch]++;
            scan_ptr = ch + 4'd1;
            break;
         end
      end
   endtask

   task automatic predict_report();
      logic [15:0]        need;
      logic [47:0]        mean_sq;
      logic [23:0]        rms_q8;
      logic [47:0]        prod;
      logic [15:0]        ma;
      channel_report_type res;
      need = (min_count == 16'd0) ? 16'd1 : min_count;
      for (int c = 0; c < 16; c++) begin
         res.updated = 1'b0;
         if (sample_cnt[c] >= need) begin
            mean_sq = {square_acc[c], 16'd0} / {32'd0, sample_cnt[c]};
            rms_q8 = root_of_mean(mean_sq);
            prod = ({24'd0, rms_q8} * {24'd0, gain_q16}) >> 24;
            ma = (prod > 48'hFFFF) ? 16'hFFFF : prod[15:0];
            if (ma < deadband) ma = 16'd0;
            held_ma[c] = ma;
            square_acc[c] = '0;
            sample_cnt[c] = '0;
            res.updated = 1'b1;
         end
         res.channel = 4'(c);
         res.irms_ma = held_ma[c];
         res.last = (c == 15);
         expected_reports.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      channel_report_type got;
      channel_report_type want;
      if (reset) begin
         present_mask <= MASK_RESET;
         min_count    <= MINSAMP_RESET;
         gain_q16     <= GAIN_RESET;
         deadband     <= DEADBAND_RESET;
         for (int c = 0; c < 16; c++) begin
            square_acc[c] = '0;
            sample_cnt[c] = '0;
            offset_val[c] = '0;
            held_ma[c] = '0;
         end
         scan_ptr = '0;
         expected_reports.delete();
         error_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_MASK:     present_mask <= csr_pwdata[15:0];
               REG_MINSAMP:  min_count <= csr_pwdata[15:0];
               REG_GAIN:     gain_q16 <= csr_pwdata[23:0];
               REG_DEADBAND: deadband <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tdata[1:0])
               OP_SAMPLE: accumulate_sample(req_tdata[11:2]);
               OP_OFFSET: offset_val[req_tdata[15:12]] = req_tdata[11:2];
               OP_REPORT: predict_report();
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[3:0], rsp_tdata[19:4], rsp_tuser, rsp_tlast};
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result ch=%0d irms=%0d upd=%0b last=%0b", $time,
                        got.channel, got.irms_ma, got.updated, got.last);
               error_count <= error_count + 1;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want || rsp_tdata[23:20] !== 4'd0) begin
                  $display("%0t: mismatch expected ch=%0d irms=%0d upd=%0b last=%0b",
                           $time, want.channel, want.irms_ma, want.updated, want.last);
                  $display("%0t:          actual   ch=%0d irms=%0d upd=%0b last=%0b fill=%h",
                           $time, got.channel, got.irms_ma, got.updated, got.last,
                           rsp_tdata[23:20]);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

/* sim/multichannel_rms_current_monitor_tb.sv */
// Testbench top for the RMS current monitor: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module multichannel_rms_current_monitor_tb;
   import mrcm_pkg::*;

   // Cycles without any accepted item before the run is declared hung. The
   // limit covers the computation of a recomputed channel before its result
   // is offered, plus the long receiver hold-off.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count;
   int pending;
   int idle_cycles = 0;
   // When set, neither side inserts gaps, giving stretches of full throughput.
   logic no_gaps = 1'b0;
   // Each increment asks the receiver process for one long hold-off.
   int hold_requests = 0;

   always #5 clock = ~clock;

   multichannel_rms_current_monitor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mrcm_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .error_count(error_count), .pending(pending)
   );

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls at random, and on request holds off for a long,
   // counted stretch so that the block fills up and stops taking items.
   always @(posedge clock) begin
      static int stall_left = 0;
      static int holds_done = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done = hold_requests;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = random_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   // The watchdog restarts whenever any of the three ports accepts something.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item and returns at the edge where it is taken. The valid is
   // only lowered when a gap is wanted, so back-to-back items keep it high.
   task automatic send_item(input logic [1:0] op, input logic [9:0] adc, input logic [3:0] tgt);
      int gap;
      gap = no_gaps ? 0 : random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {tgt, adc, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every expected result is in; samples
   // and offset writes give no result, so a closing wait lets them retire.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] mask, input logic [15:0] min_n,
                            input logic [23:0] gain, input logic [15:0] dead);
      drain();
      write_register(REG_MASK, {16'd0, mask});
      write_register(REG_MINSAMP, {16'd0, min_n});
      write_register(REG_GAIN, {8'd0, gain});
      write_register(REG_DEADBAND, {16'd0, dead});
   endtask

   // A random item: mostly samples, so that channels reach their thresholds,
   // with offset writes, reports and the unused op code mixed in.
   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 68) send_item(OP_SAMPLE, 10'($urandom), 4'($urandom));
      else if (r < 82) send_item(OP_OFFSET, 10'($urandom), 4'($urandom));
      else if (r < 95) send_item(OP_REPORT, 10'($urandom), 4'($urandom));
      else send_item(2'd3, 10'($urandom), 4'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: extreme offsets and samples,
      // the unused op code and a report of the untouched channels.
      send_item(OP_REPORT, 10'd0, 4'd0);
      send_item(OP_OFFSET, 10'd1023, 4'd0);
      send_item(OP_OFFSET, 10'd0, 4'd15);
      send_item(OP_OFFSET, 10'd512, 4'd5);
      send_item(2'd3, 10'd1023, 4'd15);
      send_item(OP_SAMPLE, 10'd0, 4'd0);
      send_item(OP_SAMPLE, 10'd1023, 4'd0);
      send_item(OP_SAMPLE, 10'd1023, 4'd15);
      send_item(OP_SAMPLE, 10'd0, 4'd0);

      // Zero threshold counts as one; maximum gain saturates the current.
      configure(16'hFFFF, 16'd0, 24'hFF_FFFF, 16'd0);
      for (int i = 0; i < 16; i++) send_item(OP_SAMPLE, (i[0] ? 10'd1023 : 10'd0), 4'd0);
      send_item(OP_REPORT, 10'd0, 4'd0);
      send_item(OP_REPORT, 10'd0, 4'd0);

      // No channel fitted: samples are ignored and reports hold everything.
      configure(16'h0000, 16'd1, GAIN_RESET, 16'd0);
      send_item(OP_SAMPLE, 10'd1023, 4'd0);
      send_item(OP_SAMPLE, 10'd0, 4'd0);
      send_item(OP_REPORT, 10'd0, 4'd0);

      // Channel 0 alone, offset at full scale and zero samples, so each
      // square is the largest possible, under the widest deadband.
      configure(16'h0001, 16'd1, GAIN_RESET, 16'hFFFF);
      no_gaps <= 1'b1;
      for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, 10'd0, 4'd0);
      send_item(OP_REPORT, 10'd0, 4'd0);
      no_gaps <= 1'b0;

      // Random phases, among them the extreme settings.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(16'hFFFF, 16'd1, 24'hFF_FFFF, 16'd0);
            1: configure(16'($urandom), 16'd3, GAIN_RESET, DEADBAND_RESET);
            2: configure(16'h8001, 16'd2, 24'd0, 16'hFFFF);
            default: configure(16'($urandom), 16'($urandom_range(1, 5)),
                               24'($urandom), 16'($urandom_range(0, 2000)));
         endcase
         if (phase == 1) no_gaps <= 1'b1;
         for (int i = 0; i < 30; i++) random_item();
         no_gaps <= 1'b0;
         if (phase == 2) begin
            // The receiver holds off while reports keep coming.
            hold_requests <= hold_requests + 1;
            for (int i = 0; i < 4; i++) send_item(OP_REPORT, 10'($urandom), 4'($urandom));
         end
      end
      // A final run at the largest threshold leaves counts short of it.
      configure(16'($urandom), 16'hFFFF, GAIN_RESET, DEADBAND_RESET);
      for (int i = 0; i < 10; i++) random_item();
      send_item(OP_REPORT, 10'd0, 4'd0);

      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
